/* src/lens_shading_word_blend_scale_defines.svh */
// assertion macros for the lens shading word blend and scale block
`ifndef LENS_SHADING_WORD_BLEND_SCALE_DEFINES_SVH
`define LENS_SHADING_WORD_BLEND_SCALE_DEFINES_SVH

// same-cycle implication
`define LSWBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lswbs check failed");

// next-cycle implication
`define LSWBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lswbs check failed");

`endif

/* src/lswbs_pkg.sv */
// types, constants and helpers shared by the lens shading word blend and scale block
package lswbs_pkg;

  localparam int unsigned MAX_WORDS = 2047;
  localparam int unsigned IDX_W     = 11;
  localparam int unsigned ENTRY_W   = 10;
  localparam int unsigned HALF_W    = 12;
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned WEIGHT_W  = 13;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // reciprocal of three for an 11-bit index
  localparam logic [ENTRY_W-1:0] RECIP3 = 10'd683;

  localparam logic [HALF_W-1:0] HALF_MAX = 12'hfff;
  localparam logic [HALF_W-1:0] BASE_MAX = 12'h800;
  localparam logic [CFG_W-1:0]  STRENGTH_UNITY = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TEMP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_D    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MESH_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH    = 3'd6;

  typedef enum logic [2:0] {
    MODE_LOW      = 3'd0,
    MODE_BLEND_LM = 3'd1,
    MODE_MID      = 3'd2,
    MODE_BLEND_MH = 3'd3,
    MODE_HIGH     = 3'd4
  } lswbs_mode_e;

  typedef struct packed {
    lswbs_mode_e         mode;
    logic [WEIGHT_W-1:0] weight;
  } lswbs_sel_t;

  typedef struct packed {
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_low_ct;
    logic [WORD_W-1:0] word_mid_ct;
    logic [WORD_W-1:0] word_high_ct;
  } lswbs_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic [1:0]         channel;
    logic [WORD_W-1:0]  shaded_word;
  } lswbs_out_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic [1:0]         channel;
    logic [WORD_W-1:0]  word;
  } lswbs_mid_t;

  // saturate a signed value to 0..4095
  function automatic logic [HALF_W-1:0] clamp12(input logic signed [19:0] v);
    logic [HALF_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({8'd0, HALF_MAX})) begin
      r = HALF_MAX;
    end else begin
      r = v[HALF_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/lswbs_weight_div.sv */
// table choice and blend weight, found by a bit-serial restoring divider
module lswbs_weight_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     restart_i,
  input  logic [15:0]              color_temp_i,
  input  logic [15:0]              thresh_a_i,
  input  logic [15:0]              thresh_b_i,
  input  logic [15:0]              thresh_c_i,
  input  logic [15:0]              thresh_d_i,
  output lswbs_pkg::lswbs_sel_t    sel_o,
  output logic                     busy_o
);
  import lswbs_pkg::*;

  localparam int unsigned NUM_W = CFG_W + HALF_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;

  logic [1:0]          state_q, state_d;
  lswbs_mode_e         mode_q, mode_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [CFG_W-1:0]    den_q, den_d;
  logic [CFG_W-1:0]    rem_q, rem_d;
  logic [WEIGHT_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [CFG_W:0] rem_sh;
  logic [CFG_W:0] rem_sub;
  logic           q_bit;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_bit   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_SETUP: begin
        rem_d = '0;
        quo_d = '0;
        cnt_d = '0;
        if (color_temp_i <= thresh_a_i) begin
          mode_d  = MODE_LOW;
          state_d = ST_IDLE;
        end else if (color_temp_i <= thresh_b_i) begin
          mode_d  = MODE_BLEND_LM;
          num_d   = {color_temp_i - thresh_a_i, {HALF_W{1'b0}}};
          den_d   = thresh_b_i - thresh_a_i;
          state_d = ST_DIV;
        end else if (color_temp_i <= thresh_c_i) begin
          mode_d  = MODE_MID;
          state_d = ST_IDLE;
        end else if (color_temp_i <= thresh_d_i) begin
          mode_d  = MODE_BLEND_MH;
          num_d   = {color_temp_i - thresh_c_i, {HALF_W{1'b0}}};
          den_d   = thresh_d_i - thresh_c_i;
          state_d = ST_DIV;
        end else begin
          mode_d  = MODE_HIGH;
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        num_d = {num_q[NUM_W-2:0], 1'b0};
        rem_d = q_bit ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
        quo_d = {quo_q[WEIGHT_W-2:0], q_bit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (restart_i) begin
      state_d = ST_SETUP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SETUP;
      mode_q  <= MODE_LOW;
      quo_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      quo_q   <= quo_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign sel_o.mode   = mode_q;
  assign sel_o.weight = quo_q;
  assign busy_o       = (state_q != ST_IDLE);

endmodule

/* src/lswbs_blend.sv */
// table word selection and two-table blend, three register stages
module lswbs_blend (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  lswbs_pkg::lswbs_in_t   in_i,
  input  lswbs_pkg::lswbs_sel_t  sel_i,
  output logic                   mid_valid_o,
  output lswbs_pkg::lswbs_mid_t  mid_o
);
  import lswbs_pkg::*;

  localparam int unsigned PROD_W = HALF_W + 1 + WEIGHT_W + 1;
  localparam int unsigned RCP_W  = IDX_W + ENTRY_W;

  logic [WORD_W-1:0]  word_a, word_b;
  logic [RCP_W-1:0]   rcp;
  logic               in_ok;

  // stage 1
  logic               v1_q;
  logic [IDX_W-1:0]   idx1_q;
  logic [ENTRY_W-1:0] entry1_q;
  logic [HALF_W-1:0]  a_hi1_q, a_lo1_q;
  logic signed [HALF_W:0] d_hi1_q, d_lo1_q;

  // stage 2
  logic               v2_q;
  logic [ENTRY_W-1:0] entry2_q;
  logic [1:0]         ch2_q;
  logic [HALF_W-1:0]  a_hi2_q, a_lo2_q;
  logic signed [PROD_W-1:0] p_hi2_q, p_lo2_q;
  logic [IDX_W-1:0]   three_e;

  // stage 3
  logic               v3_q;
  lswbs_mid_t         mid3_q;
  logic signed [19:0] s_hi, s_lo;

  always_comb begin
    unique case (sel_i.mode)
      MODE_LOW: begin
        word_a = in_i.word_low_ct;
        word_b = in_i.word_low_ct;
      end
      MODE_BLEND_LM: begin
        word_a = in_i.word_low_ct;
        word_b = in_i.word_mid_ct;
      end
      MODE_MID: begin
        word_a = in_i.word_mid_ct;
        word_b = in_i.word_mid_ct;
      end
      MODE_BLEND_MH: begin
        word_a = in_i.word_mid_ct;
        word_b = in_i.word_high_ct;
      end
      default: begin
        word_a = in_i.word_high_ct;
        word_b = in_i.word_high_ct;
      end
    endcase
  end

  assign rcp   = RCP_W'(in_i.word_index) * RCP_W'(RECIP3);
  assign in_ok = (12'(in_i.word_index) < 12'(MAX_WORDS));

  assign three_e = {entry1_q, 1'b0} + {1'b0, entry1_q};

  assign s_hi = $signed({8'd0, a_hi2_q}) +
                20'($signed(p_hi2_q[PROD_W-1:HALF_W]));
  assign s_lo = $signed({8'd0, a_lo2_q}) +
                20'($signed(p_lo2_q[PROD_W-1:HALF_W]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i && in_ok;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q   <= in_i.word_index;
    entry1_q <= rcp[RCP_W-1:IDX_W];
    a_hi1_q  <= word_a[WORD_W-1:HALF_W];
    a_lo1_q  <= word_a[HALF_W-1:0];
    d_hi1_q  <= $signed({1'b0, word_b[WORD_W-1:HALF_W]}) -
                $signed({1'b0, word_a[WORD_W-1:HALF_W]});
    d_lo1_q  <= $signed({1'b0, word_b[HALF_W-1:0]}) -
                $signed({1'b0, word_a[HALF_W-1:0]});

    entry2_q <= entry1_q;
    ch2_q    <= 2'(idx1_q - three_e);
    a_hi2_q  <= a_hi1_q;
    a_lo2_q  <= a_lo1_q;
    p_hi2_q  <= PROD_W'(d_hi1_q * $signed({1'b0, sel_i.weight}));
    p_lo2_q  <= PROD_W'(d_lo1_q * $signed({1'b0, sel_i.weight}));

    mid3_q.entry_index <= entry2_q;
    mid3_q.channel     <= ch2_q;
    mid3_q.word        <= {clamp12(s_hi), clamp12(s_lo)};
  end

  assign mid_valid_o = v3_q;
  assign mid_o       = mid3_q;

endmodule

/* src/lswbs_scale.sv */
// strength scaling about the base level, two register stages
module lswbs_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   mid_valid_i,
  input  lswbs_pkg::lswbs_mid_t  mid_i,
  input  logic [1:0]             scale_sel_i,
  input  logic [15:0]            strength_i,
  output logic                   result_valid_o,
  output lswbs_pkg::lswbs_out_t  result_o
);
  import lswbs_pkg::*;

  localparam int unsigned PROD_W = HALF_W + 1 + CFG_W + 1;

  logic [HALF_W-1:0] base;
  logic signed [HALF_W:0] d_hi, d_lo;

  logic               v4_q;
  logic [ENTRY_W-1:0] entry4_q;
  logic [1:0]         ch4_q;
  logic signed [PROD_W-1:0] p_hi4_q, p_lo4_q;

  logic               v5_q;
  lswbs_out_t         out5_q;
  logic signed [19:0] s_hi, s_lo;

  assign base = BASE_MAX >> scale_sel_i;

  assign d_hi = $signed({1'b0, mid_i.word[WORD_W-1:HALF_W]}) - $signed({1'b0, base});
  assign d_lo = $signed({1'b0, mid_i.word[HALF_W-1:0]}) - $signed({1'b0, base});

  assign s_hi = $signed({8'd0, base}) + 20'($signed(p_hi4_q[PROD_W-1:HALF_W]));
  assign s_lo = $signed({8'd0, base}) + 20'($signed(p_lo4_q[PROD_W-1:HALF_W]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= mid_valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry4_q <= mid_i.entry_index;
    ch4_q    <= mid_i.channel;
    p_hi4_q  <= PROD_W'(d_hi * $signed({1'b0, strength_i}));
    p_lo4_q  <= PROD_W'(d_lo * $signed({1'b0, strength_i}));

    out5_q.entry_index <= entry4_q;
    out5_q.channel     <= ch4_q;
    out5_q.shaded_word <= {clamp12(s_hi), clamp12(s_lo)};
  end

  assign result_valid_o = v5_q;
  assign result_o       = out5_q;

endmodule

/* src/lens_shading_word_blend_scale.sv */
// top level of the lens shading word blend and scale block
// An item is taken at a clock edge with start_i high and busy_o low, one item
// per cycle, and its result appears on result_o with result_valid_o high for
// exactly one cycle, after the blend and scale register stages, in order; the
// receiver cannot stall. Items whose word_index is 2047 or above give no result.
// Every configuration write, and reset, restarts the table choice and the
// weight divider, which resolves one quotient bit per cycle: busy_o stays high
// through the setup state and, in a blend region, through the divide state.
// Write configuration only when no item is in flight.
module lens_shading_word_blend_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  lswbs_pkg::lswbs_in_t   in_i,
  output logic                   result_valid_o,
  output lswbs_pkg::lswbs_out_t  result_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i
);
  import lswbs_pkg::*;

  logic [CFG_W-1:0] color_temp_q, thresh_a_q, thresh_b_q, thresh_c_q, thresh_d_q;
  logic [CFG_W-1:0] strength_q;
  logic [1:0]       scale_sel_q;
  logic             cfg_we;
  logic             accept;

  lswbs_sel_t       sel;
  logic             mid_valid;
  lswbs_mid_t       mid;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_temp_q <= '0;
      thresh_a_q   <= '0;
      thresh_b_q   <= '0;
      thresh_c_q   <= '0;
      thresh_d_q   <= '0;
      scale_sel_q  <= '0;
      strength_q   <= STRENGTH_UNITY;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_COLOR_TEMP: color_temp_q <= cfg_data_i;
        REG_THRESH_A:   thresh_a_q   <= cfg_data_i;
        REG_THRESH_B:   thresh_b_q   <= cfg_data_i;
        REG_THRESH_C:   thresh_c_q   <= cfg_data_i;
        REG_THRESH_D:   thresh_d_q   <= cfg_data_i;
        REG_MESH_SCALE: scale_sel_q  <= cfg_data_i[1:0];
        REG_STRENGTH:   strength_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lswbs_weight_div u_weight_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_we),
    .color_temp_i (color_temp_q),
    .thresh_a_i   (thresh_a_q),
    .thresh_b_i   (thresh_b_q),
    .thresh_c_i   (thresh_c_q),
    .thresh_d_i   (thresh_d_q),
    .sel_o        (sel),
    .busy_o       (busy_o)
  );

  lswbs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_i        (in_i),
    .sel_i       (sel),
    .mid_valid_o (mid_valid),
    .mid_o       (mid)
  );

  lswbs_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mid_valid_i    (mid_valid),
    .mid_i          (mid),
    .scale_sel_i    (scale_sel_q),
    .strength_i     (strength_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* src/lswbs_checker.sv */
// port-level checks for the lens shading word blend and scale block
`include "lens_shading_word_blend_scale_defines.svh"

module lswbs_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  logic result_valid_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i
);

  // a config write restarts the weight computation
  `LSWBS_ASSERT_NXT(a_cfg_sets_busy, clk_i, rst_ni, cfg_valid_i && cfg_ready_i, busy_i)

  // busy only rises after a config write
  `LSWBS_ASSERT_IMP(a_busy_rise_cause, clk_i, rst_ni, $rose(busy_i), $past(cfg_valid_i && cfg_ready_i))

  // every result comes from an item taken earlier at the input
  `LSWBS_ASSERT_IMP(a_result_latency, clk_i, rst_ni, result_valid_i, $past(start_i && !busy_i, 5))

endmodule

bind lens_shading_word_blend_scale lswbs_checker u_lswbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_i         (busy_o),
  .result_valid_i (result_valid_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_i    (cfg_ready_o)
);

/* sim/lens_shading_word_blend_scale_tb.sv */
// testbench for the lens shading word blend and scale block, checked against its own predictor
`timescale 1ns / 1ps

module lens_shading_word_blend_scale_tb;
  import lswbs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned RANDOM_PER_PHASE = 52;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lswbs_in_t word_in = '0;
  logic result_valid;
  lswbs_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [CFG_W-1:0] cur_ct = 16'd0;
  logic [CFG_W-1:0] cur_ta = 16'd0;
  logic [CFG_W-1:0] cur_tb = 16'd0;
  logic [CFG_W-1:0] cur_tc = 16'd0;
  logic [CFG_W-1:0] cur_td = 16'd0;
  logic [1:0] cur_scale = 2'd0;
  logic [CFG_W-1:0] cur_strength = STRENGTH_UNITY;

  lswbs_in_t pending_words[$];
  lswbs_out_t expected_shading[$];
  logic item_taken = 1'b0;
  int gap_pct = 23;
  int err_count = 0;

  lens_shading_word_blend_scale dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .start_i(start),
    .busy_o(busy),
    .in_i(word_in),
    .result_valid_o(result_valid),
    .result_o(result),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [HALF_W-1:0] sat12(longint v);
    if (v < 0) begin
      return '0;
    end else if (v > 4095) begin
      return 12'hfff;
    end
    return v[HALF_W-1:0];
  endfunction

  // x + (y - x) * w / 4096, floored
  function automatic logic [HALF_W-1:0] mix_half(logic [HALF_W-1:0] x, logic [HALF_W-1:0] y,
                                                 logic [31:0] w);
    longint xs, ys, ws;
    xs = longint'(x);
    ys = longint'(y);
    ws = longint'(w);
    return sat12(xs + (((ys - xs) * ws) >>> 12));
  endfunction

  function automatic logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                                                 logic [31:0] w);
    return {mix_half(x[23:12], y[23:12], w), mix_half(x[11:0], y[11:0], w)};
  endfunction

  function automatic lswbs_out_t shade_word(lswbs_in_t it);
    logic [WORD_W-1:0] picked;
    logic [31:0] num, den, weight;
    logic [HALF_W-1:0] base;
    lswbs_out_t r;
    if (cur_ct <= cur_ta) begin
      picked = it.word_low_ct;
    end else if (cur_ct <= cur_tb) begin
      num = 32'(cur_ct - cur_ta);
      den = 32'(cur_tb - cur_ta);
      weight = (num << 12) / den;
      picked = mix_word(it.word_low_ct, it.word_mid_ct, weight);
    end else if (cur_ct <= cur_tc) begin
      picked = it.word_mid_ct;
    end else if (cur_ct <= cur_td) begin
      num = 32'(cur_ct - cur_tc);
      den = 32'(cur_td - cur_tc);
      weight = (num << 12) / den;
      picked = mix_word(it.word_mid_ct, it.word_high_ct, weight);
    end else begin
      picked = it.word_high_ct;
    end
    base = 12'h800 >> cur_scale;
    r.entry_index = ENTRY_W'(it.word_index / 11'd3);
    r.channel = 2'(it.word_index % 11'd3);
    r.shaded_word = {mix_half(base, picked[23:12], {16'd0, cur_strength}),
                     mix_half(base, picked[11:0], {16'd0, cur_strength})};
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!start || item_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        start <= 1'b1;
        word_in <= pending_words.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lswbs_out_t want;
    if (rst_n) begin
      item_taken <= start && !busy;
      if (start && !busy && word_in.word_index < MAX_WORDS) begin
        expected_shading.push_back(shade_word(word_in));
      end
      if (result_valid) begin
        if (expected_shading.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result));
        end else begin
          want = expected_shading.pop_front();
          if (result.entry_index !== want.entry_index) begin
            report_mismatch($sformatf("entry_index got %0d expected %0d",
                                      result.entry_index, want.entry_index));
          end
          if (result.channel !== want.channel) begin
            report_mismatch($sformatf("channel got %0d expected %0d",
                                      result.channel, want.channel));
          end
          if (result.shaded_word !== want.shaded_word) begin
            report_mismatch($sformatf("shaded_word got %h expected %h (entry %0d)",
                                      result.shaded_word, want.shaded_word, want.entry_index));
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COLOR_TEMP: cur_ct = data;
      REG_THRESH_A:   cur_ta = data;
      REG_THRESH_B:   cur_tb = data;
      REG_THRESH_C:   cur_tc = data;
      REG_THRESH_D:   cur_td = data;
      REG_MESH_SCALE: cur_scale = data[1:0];
      REG_STRENGTH:   cur_strength = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] ct, logic [15:0] a, logic [15:0] b,
                               logic [15:0] c, logic [15:0] d, logic [1:0] sel,
                               logic [15:0] strength);
    write_reg(REG_THRESH_A, a);
    write_reg(REG_THRESH_B, b);
    write_reg(REG_THRESH_C, c);
    write_reg(REG_THRESH_D, d);
    write_reg(REG_MESH_SCALE, {14'd0, sel});
    write_reg(REG_STRENGTH, strength);
    write_reg(REG_COLOR_TEMP, ct);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setting();
    logic [15:0] a, b, c, d, ct, strength;
    if ($urandom_range(0, 3) == 0) begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      d = 16'($urandom);
    end else begin
      a = 16'($urandom_range(0, 20000));
      b = 16'(a + $urandom_range(0, 15000));
      c = 16'(b + $urandom_range(0, 15000));
      d = 16'(c + $urandom_range(0, 15000));
    end
    case ($urandom_range(0, 4))
      0: ct = 16'($urandom_range(0, a));
      1: ct = 16'($urandom_range(a, b));
      2: ct = 16'($urandom_range(b, c));
      3: ct = 16'($urandom_range(c, d));
      default: ct = 16'($urandom_range(d, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: strength = 16'd0;
      1: strength = 16'hffff;
      2: strength = STRENGTH_UNITY;
      default: strength = 16'($urandom);
    endcase
    apply_setting(ct, a, b, c, d, 2'($urandom_range(0, 3)), strength);
  endtask

  // wait until nothing is in flight
  task automatic wait_idle();
    while (pending_words.size() != 0 || start || expected_shading.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [HALF_W-1:0] pick_half();
    case ($urandom_range(0, 6))
      0: return 12'h000;
      1: return 12'hfff;
      2: return 12'h800;
      3: return 12'h400;
      4: return 12'h200;
      5: return 12'h100;
      default: return HALF_W'($urandom);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(0, 3) == 0) begin
      return {pick_half(), pick_half()};
    end
    return WORD_W'($urandom);
  endfunction

  task automatic push_word(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] lo,
                           logic [WORD_W-1:0] mi, logic [WORD_W-1:0] hi);
    lswbs_in_t it;
    it.word_index = idx;
    it.word_low_ct = lo;
    it.word_mid_ct = mi;
    it.word_high_ct = hi;
    pending_words.push_back(it);
  endtask

  task automatic push_corners();
    push_word(11'd0, 24'h000000, 24'hffffff, 24'h800800);
    push_word(11'd2046, 24'hffffff, 24'h000fff, 24'hfff000);
    push_word(11'd2047, pick_word(), pick_word(), pick_word());
  endtask

  task automatic push_random(int n);
    int valid_count;
    logic [IDX_W-1:0] idx;
    valid_count = 0;
    while (valid_count < n) begin
      case ($urandom_range(0, 19))
        0: idx = 11'd2047;
        1: idx = 11'd2046;
        2: idx = 11'd0;
        default: idx = IDX_W'($urandom_range(0, 2046));
      endcase
      if (idx < MAX_WORDS) begin
        valid_count++;
      end
      push_word(idx, pick_word(), pick_word(), pick_word());
    end
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: low table, unity strength
    push_corners();
    push_word(11'd1, 24'h001ffe, pick_word(), pick_word());
    push_word(11'd2, 24'h7ff801, pick_word(), pick_word());
    push_word(11'd2045, 24'haaa555, pick_word(), pick_word());
    push_random(RANDOM_PER_PHASE);
    wait_idle();

    for (phase = 1; phase < 14; phase++) begin
      gap_pct = (phase < 5) ? 23 : (phase < 10) ? 57 : 0;
      case (phase)
        1: apply_setting(16'd100, 16'd1000, 16'd3000, 16'd5000, 16'd8000, 2'd0, 16'd4096);
        2: apply_setting(16'd2000, 16'd1000, 16'd3000, 16'd5000, 16'd8000, 2'd1, 16'd5000);
        3: apply_setting(16'd4000, 16'd1000, 16'd3000, 16'd5000, 16'd8000, 2'd2, 16'd0);
        4: apply_setting(16'd7999, 16'd1000, 16'd3000, 16'd5000, 16'd8000, 2'd3, 16'hffff);
        5: apply_setting(16'hffff, 16'd1000, 16'd3000, 16'd5000, 16'd8000, 2'd0, 16'd2048);
        6: apply_setting(16'hffff, 16'd0, 16'hffff, 16'hffff, 16'hffff, 2'd1, 16'd4096);
        7: apply_setting(16'd1, 16'd0, 16'hffff, 16'hffff, 16'hffff, 2'd2, 16'd8192);
        8: apply_setting(16'd40000, 16'd0, 16'd0, 16'd30000, 16'd50000, 2'd3, 16'd4096);
        default: random_setting();
      endcase
      if (phase == 1) begin
        // write to an index past the last register must change nothing
        write_reg(REG_UNUSED, 16'hffff);
        @(negedge clk);
        cfg_valid <= 1'b0;
      end
      if (phase <= 5) begin
        push_corners();
      end
      push_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
